FILE: design/utf8sd_pkg.sv
package utf8sd_pkg;

    // Default width of the internal byte position counters
    localparam int unsigned OFFSET_BITS_DEF = 16;

    localparam int unsigned CP_BITS  = 21;
    localparam int unsigned OFF_BITS = 16;

    // Scalar value limits
    localparam logic [CP_BITS-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_BITS-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_BITS-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [CP_BITS-1:0] REPL_RESET = 21'h00FFFD;

    // Longest sequence, in bytes
    localparam logic [2:0] SEQ_MAX = 3'd4;

    // Result queue depth
    localparam int unsigned QUEUE_DEPTH = 4;

    // Configuration register indexes
    typedef enum logic {
        CFG_STRICT_MODE      = 1'b0,
        CFG_REPLACEMENT_CHAR = 1'b1
    } t_cfg_index;

    // One result item
    typedef struct packed {
        logic                has_char;
        logic [CP_BITS-1:0]  code_point;
        logic                is_error;
        logic [OFF_BITS-1:0] error_offset;
        logic                text_done;
        logic                run_last;
    } t_result;

    // Results produced by one accepted byte, handed to the queue
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

FILE: design/utf8sd_decode.sv
module utf8sd_decode #(
    parameter int unsigned OFFSET_BITS = utf8sd_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_end_of_text,
    input  logic                   i_cfg_we,
    input  utf8sd_pkg::t_cfg_index i_cfg_index,
    input  logic [20:0]            i_cfg_data,
    output utf8sd_pkg::t_push      o_push
);
    import utf8sd_pkg::*;

    logic                   r_strict;
    logic [CP_BITS-1:0]     r_repl;
    logic [CP_BITS-1:0]     r_partial,  n_partial;
    logic [2:0]             r_exp,      n_exp;
    logic [2:0]             r_taken,    n_taken;
    logic                   r_skipping, n_skipping;
    logic [OFFSET_BITS-1:0] r_pos,      n_pos;
    logic [OFFSET_BITS-1:0] r_seq,      n_seq;
    logic                   r_halted,   n_halted;
    t_result                res0, res1;
    logic [1:0]             cnt;

    // Build the result for a bad sequence starting at off
    function automatic t_result bad_res(input logic strict, input logic [CP_BITS-1:0] repl,
                                        input logic [OFFSET_BITS-1:0] off);
        t_result r;
        r = '0;
        if (strict) begin
            r.is_error     = 1'b1;
            r.error_offset = (64'(off) > 64'hFFFF) ? 16'hFFFF : OFF_BITS'(off);
            r.text_done    = 1'b1;
        end else begin
            r.has_char   = 1'b1;
            r.code_point = repl;
        end
        return r;
    endfunction

    function automatic t_result char_res(input logic [CP_BITS-1:0] cp);
        t_result r;
        r = '0;
        r.has_char   = 1'b1;
        r.code_point = cp;
        return r;
    endfunction

    // Work out the next text state and the results of one byte
    always_comb begin
        logic                   cont;
        logic                   handle;
        logic                   go_start;
        logic [OFFSET_BITS-1:0] at;
        t_result                r;

        n_partial  = r_partial;
        n_exp      = r_exp;
        n_taken    = r_taken;
        n_skipping = r_skipping;
        n_seq      = r_seq;
        n_halted   = r_halted;
        res0       = '0;
        res1       = '0;
        cnt        = 2'd0;
        handle     = 1'b1;
        go_start   = 1'b0;
        r          = '0;
        at         = r_pos;
        n_pos      = (r_pos != '1) ? r_pos + 1'b1 : r_pos;
        cont       = (i_data_byte[7:6] == 2'b10);

        if (r_halted) begin
            if (i_end_of_text) begin
                n_partial  = '0;
                n_exp      = '0;
                n_taken    = '0;
                n_skipping = 1'b0;
                n_pos      = '0;
                n_seq      = '0;
                n_halted   = 1'b0;
            end
        end else begin
            // Drop continuation bytes left over from a replaced sequence
            if (r_skipping) begin
                if (cont && r_taken < SEQ_MAX) begin
                    n_taken = r_taken + 3'd1;
                    if (n_taken >= SEQ_MAX) begin
                        n_skipping = 1'b0;
                    end
                    handle = 1'b0;
                end else begin
                    n_skipping = 1'b0;
                end
            end

            // Extend a pending sequence
            if (handle) begin
                if (r_exp != 3'd0) begin
                    if (cont) begin
                        n_partial = {r_partial[CP_BITS-7:0], i_data_byte[5:0]};
                        n_taken   = r_taken + 3'd1;
                        if (n_taken >= r_exp) begin
                            if (n_partial > CP_MAX ||
                                (n_partial >= SURR_LO && n_partial <= SURR_HI)) begin
                                r         = bad_res(r_strict, r_repl, r_seq);
                                n_exp     = '0;
                                n_partial = '0;
                                if (r_strict) begin
                                    n_halted   = 1'b1;
                                    n_skipping = 1'b0;
                                end else begin
                                    n_skipping = (n_taken < SEQ_MAX);
                                end
                            end else begin
                                r         = char_res(n_partial);
                                n_exp     = '0;
                                n_partial = '0;
                            end
                            res0 = r;
                            cnt  = 2'd1;
                        end
                    end else begin
                        r         = bad_res(r_strict, r_repl, r_seq);
                        n_exp     = '0;
                        n_partial = '0;
                        if (r_strict) begin
                            n_halted   = 1'b1;
                            n_skipping = 1'b0;
                        end else begin
                            n_skipping = 1'b0;
                        end
                        res0     = r;
                        cnt      = 2'd1;
                        go_start = !n_halted;
                    end
                end else begin
                    go_start = 1'b1;
                end
            end

            // Decode the byte as a lead byte
            if (go_start) begin
                if (!i_data_byte[7]) begin
                    r = char_res(CP_BITS'(i_data_byte));
                    if (cnt[0]) res1 = r;
                    else        res0 = r;
                    cnt = cnt + 2'd1;
                end else begin
                    n_seq   = at;
                    n_taken = 3'd1;
                    if (i_data_byte >= 8'hC2 && i_data_byte <= 8'hDF) begin
                        n_exp     = 3'd2;
                        n_partial = CP_BITS'(i_data_byte & 8'h1F);
                    end else if (i_data_byte >= 8'hE0 && i_data_byte <= 8'hEF) begin
                        n_exp     = 3'd3;
                        n_partial = CP_BITS'(i_data_byte & 8'h0F);
                    end else if (i_data_byte >= 8'hF0 && i_data_byte <= 8'hF4) begin
                        n_exp     = 3'd4;
                        n_partial = CP_BITS'(i_data_byte & 8'h07);
                    end else begin
                        r         = bad_res(r_strict, r_repl, at);
                        n_exp     = '0;
                        n_partial = '0;
                        if (r_strict) begin
                            n_halted   = 1'b1;
                            n_skipping = 1'b0;
                        end else begin
                            n_skipping = 1'b1;
                        end
                        if (cnt[0]) res1 = r;
                        else        res0 = r;
                        cnt = cnt + 2'd1;
                    end
                end
            end

            // Close the text: flag a truncated sequence, mark the final result
            if (i_end_of_text) begin
                if (!n_halted && n_exp != 3'd0) begin
                    r         = bad_res(r_strict, r_repl, n_seq);
                    n_halted  = r_strict;
                    if (cnt[0]) res1 = r;
                    else        res0 = r;
                    cnt = cnt + 2'd1;
                end
                if (!n_halted) begin
                    if (cnt == 2'd0) begin
                        res0           = '0;
                        res0.text_done = 1'b1;
                        cnt            = 2'd1;
                    end else if (cnt == 2'd1) begin
                        res0.text_done = 1'b1;
                    end else begin
                        res1.text_done = 1'b1;
                    end
                end
                n_partial  = '0;
                n_exp      = '0;
                n_taken    = '0;
                n_skipping = 1'b0;
                n_pos      = '0;
                n_seq      = '0;
                n_halted   = 1'b0;
            end
        end

        // Mark the last result of this byte
        if (cnt == 2'd1) begin
            res0.run_last = 1'b1;
        end else if (cnt == 2'd2) begin
            res1.run_last = 1'b1;
        end
    end

    assign o_push.count  = i_accept ? cnt : 2'd0;
    assign o_push.first  = res0;
    assign o_push.second = res1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b0;
            r_repl   <= REPL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STRICT_MODE:      r_strict <= i_cfg_data[0];
                CFG_REPLACEMENT_CHAR: r_repl   <= i_cfg_data;
                default:              r_strict <= r_strict;
            endcase
        end
    end

    // Text state: advance on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial  <= '0;
            r_exp      <= '0;
            r_taken    <= '0;
            r_skipping <= 1'b0;
            r_pos      <= '0;
            r_seq      <= '0;
            r_halted   <= 1'b0;
        end else if (i_accept) begin
            r_partial  <= n_partial;
            r_exp      <= n_exp;
            r_taken    <= n_taken;
            r_skipping <= n_skipping;
            r_pos      <= n_pos;
            r_seq      <= n_seq;
            r_halted   <= n_halted;
        end
    end

    a_halt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (r_exp == 3'd0 && !r_skipping))
        else $error("halted with a sequence or skip pending");

    a_skip_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skipping |-> (r_exp == 3'd0 && r_taken < SEQ_MAX))
        else $error("skipping while a sequence is open or after four bytes");

    a_seq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp != 3'd0) |-> (r_taken != 3'd0 && r_taken < r_exp))
        else $error("open sequence with bad byte count");

endmodule

FILE: design/utf8sd_outq.sv
module utf8sd_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  utf8sd_pkg::t_push   i_push,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output utf8sd_pkg::t_result o_result
);
    import utf8sd_pkg::*;

    localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_result               r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_wr, n_wr;
    logic [PTR_BITS-1:0]   r_rd, n_rd;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  pop;

    assign pop      = (r_cnt != '0) && !i_stall;
    assign o_valid  = (r_cnt != '0);
    assign o_result = r_mem[r_rd];
    // Hold off new bytes unless two results fit
    assign o_full   = (r_cnt > CNT_BITS'(QUEUE_DEPTH - 2));

    // Advance pointers and fill count
    always_comb begin
        n_wr  = r_wr + PTR_BITS'(i_push.count);
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + CNT_BITS'(i_push.count) - CNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store up to two results per cycle
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 1'b1] <= i_push.second;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> !o_full)
        else $error("results pushed while queue lacks room");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

FILE: design/utf8_stream_decoder.sv
// UTF-8 to code point decoder. One byte is taken per cycle on the input
// channel while o_stall is low. Its results (zero, one or two) go into a
// four-entry result queue at the edge that accepts it. They can leave from the
// next cycle, one per cycle while i_stall is low, on the output channel.
// Bytes that make one result or none run at a full byte per clock while the
// output is not stalled; a byte that makes two results fills the queue faster
// than it drains. o_stall rises whenever the queue holds more than two results,
// since a byte may add two at once. The user must write strict_mode and
// replacement_char through the configuration port while idle; not enforced here.
module utf8_stream_decoder #(
    parameter int unsigned OFFSET_BITS = utf8sd_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_end_of_text,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_has_char,
    output logic [20:0]            o_code_point,
    output logic                   o_is_error,
    output logic [15:0]            o_error_offset,
    output logic                   o_text_done,
    output logic                   o_run_last,
    input  logic                   i_cfg_we,
    input  utf8sd_pkg::t_cfg_index i_cfg_index,
    input  logic [20:0]            i_cfg_data
);
    import utf8sd_pkg::*;

    t_push   push;
    t_result res;
    logic    accept;

    assign accept = i_valid && !o_stall;

    utf8sd_decode #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (push)
    );

    utf8sd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (res)
    );

    assign o_has_char     = res.has_char;
    assign o_code_point   = res.code_point;
    assign o_is_error     = res.is_error;
    assign o_error_offset = res.error_offset;
    assign o_text_done    = res.text_done;
    assign o_run_last     = res.run_last;

endmodule
